// ===== hdl/iqspm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqspm_pkg
// Shared types and constants of the identical-quad singular point map.
// ----------------------------------------------------------------------------
package iqspm_pkg;

    // result items emitted for every accepted input item
    localparam int RES_PER_ITEM = 8;

    // reflection code bits: bit 1 negates X, bit 0 negates Y
    localparam int REFL_NEG_X_BIT = 1;
    localparam int REFL_NEG_Y_BIT = 0;

    // reflection code of the final result of an item
    localparam logic [1:0] REFL_BOTH = 2'd3;

    // front end sequencer
    typedef enum logic [2:0] {
        FS_IDLE,
        FS_AB,
        FS_WGT1,
        FS_WGT2,
        FS_INNER_C,
        FS_INNER_D
    } t_front_state;

endpackage

// ===== hdl/identical_quad_singular_point_map_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// identical_quad_singular_point_map_core
// Maps one 4-D quadrature point and weight onto eight reflected 6-D points.
// ----------------------------------------------------------------------------
// When the output is never stalled, the back end sends one result a cycle and
// each item gives eight of them; this sets the pace at which items are taken.
// The front end works out each item on its two multipliers and runs ahead of
// the back end through a two-entry queue. Results come with reflection as the
// outer index and pyramid as the inner one; last marks the eighth.
module identical_quad_singular_point_map_core #(
    parameter int COORD_FRAC_BITS  = 16,
    parameter int WEIGHT_FRAC_BITS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [COORD_FRAC_BITS:0]          i_coord_a,
    input  logic [COORD_FRAC_BITS:0]          i_coord_b,
    input  logic [COORD_FRAC_BITS:0]          i_coord_c,
    input  logic [COORD_FRAC_BITS:0]          i_coord_d,
    input  logic [WEIGHT_FRAC_BITS:0]         i_weight_in,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [COORD_FRAC_BITS:0]          o_sum_x,
    output logic [COORD_FRAC_BITS:0]          o_sum_y,
    output logic [COORD_FRAC_BITS:0]          o_inner_u,
    output logic [COORD_FRAC_BITS:0]          o_inner_v,
    output logic signed [COORD_FRAC_BITS+1:0] o_offset_x,
    output logic signed [COORD_FRAC_BITS+1:0] o_offset_y,
    output logic [WEIGHT_FRAC_BITS:0]         o_weight_out,
    output logic                              o_pyramid,
    output logic [1:0]                        o_reflection,
    output logic                              o_last
);

    localparam int REC_W = 6 * (COORD_FRAC_BITS + 1) + 2 * (WEIGHT_FRAC_BITS + 1);

    logic             q_push, q_pop, q_full, q_empty;
    logic [REC_W-1:0] q_wdata, q_rdata;

    iqspm_front #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_coord_a  (i_coord_a),
        .i_coord_b  (i_coord_b),
        .i_coord_c  (i_coord_c),
        .i_coord_d  (i_coord_d),
        .i_weight_in(i_weight_in),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_data   (q_wdata)
    );

    iqspm_fifo #(
        .WIDTH(REC_W),
        .DEPTH(2)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (q_wdata),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_empty(q_empty),
        .o_data (q_rdata)
    );

    iqspm_back #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_data    (q_rdata),
        .o_q_pop     (q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_sum_x     (o_sum_x),
        .o_sum_y     (o_sum_y),
        .o_inner_u   (o_inner_u),
        .o_inner_v   (o_inner_v),
        .o_offset_x  (o_offset_x),
        .o_offset_y  (o_offset_y),
        .o_weight_out(o_weight_out),
        .o_pyramid   (o_pyramid),
        .o_reflection(o_reflection),
        .o_last      (o_last)
    );

endmodule

// ===== hdl/iqspm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqspm_front
// Accepts an item, saturates it and works out every product that its eight
// results share, on two multipliers over five steps, then queues the record.
// ----------------------------------------------------------------------------
module iqspm_front #(
    parameter int COORD_FRAC_BITS  = 16,
    parameter int WEIGHT_FRAC_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [COORD_FRAC_BITS:0]      i_coord_a,
    input  logic [COORD_FRAC_BITS:0]      i_coord_b,
    input  logic [COORD_FRAC_BITS:0]      i_coord_c,
    input  logic [COORD_FRAC_BITS:0]      i_coord_d,
    input  logic [WEIGHT_FRAC_BITS:0]     i_weight_in,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output logic [6*(COORD_FRAC_BITS+1)+2*(WEIGHT_FRAC_BITS+1)-1:0] o_q_data
);

    localparam int CW = COORD_FRAC_BITS + 1;
    localparam int WW = WEIGHT_FRAC_BITS + 1;
    localparam int MW = (WW > CW) ? WW : CW;
    localparam logic [CW-1:0] CONE = CW'(1) << COORD_FRAC_BITS;
    localparam logic [WW-1:0] WONE = WW'(1) << WEIGHT_FRAC_BITS;

    // floor(x*y / 2^COORD_FRAC_BITS) with y <= 1.0, so the result fits x's width
    function automatic logic [MW-1:0] mul_q(input logic [MW-1:0] x,
                                            input logic [CW-1:0] y);
        logic [MW+CW-1:0] prod;
        prod = MW'(x) * y;
        return prod[COORD_FRAC_BITS+MW-1:COORD_FRAC_BITS];
    endfunction

    iqspm_pkg::t_front_state r_state, n_state;

    logic [CW-1:0] r_a, r_b, r_c, r_d;
    logic [WW-1:0] r_w;
    logic [CW-1:0] r_ab;
    logic [MW-1:0] r_aw, r_t0, r_t1;
    logic [WW-1:0] r_wt0, r_wt1;
    logic [CW-1:0] r_cu0, r_cu1;

    logic          accept;
    logic [CW-1:0] one_m_a, one_m_ab;
    logic [MW-1:0] mx_a, mx_b, prod_a, prod_b;
    logic [CW-1:0] my_a, my_b;

    assign one_m_a  = CONE - r_a;
    assign one_m_ab = CONE - r_ab;
    assign accept   = i_valid && o_ready;

    // operand selection for the two shared multipliers
    always_comb begin
        mx_a = MW'(r_a);
        my_a = r_b;
        mx_b = MW'(r_w);
        my_b = r_a;
        unique case (r_state)
            iqspm_pkg::FS_WGT1: begin
                mx_a = r_aw;
                my_a = one_m_ab;
                mx_b = r_aw;
                my_b = one_m_a;
            end
            iqspm_pkg::FS_WGT2: begin
                mx_a = r_t0;
                my_a = one_m_a;
                mx_b = r_t1;
                my_b = one_m_ab;
            end
            iqspm_pkg::FS_INNER_C: begin
                mx_a = MW'(one_m_ab);
                my_a = r_c;
                mx_b = MW'(one_m_a);
                my_b = r_c;
            end
            iqspm_pkg::FS_INNER_D: begin
                mx_a = MW'(one_m_a);
                my_a = r_d;
                mx_b = MW'(one_m_ab);
                my_b = r_d;
            end
            default: begin
            end
        endcase
    end

    assign prod_a = mul_q(mx_a, my_a);
    assign prod_b = mul_q(mx_b, my_b);

    assign o_q_data = {r_a, r_ab, r_cu0, r_cu1, prod_a[CW-1:0], prod_b[CW-1:0], r_wt0, r_wt1};

    always_comb begin
        n_state  = r_state;
        o_q_push = 1'b0;
        o_ready  = 1'b0;
        unique case (r_state)
            iqspm_pkg::FS_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = iqspm_pkg::FS_AB;
                end
            end
            iqspm_pkg::FS_AB:      n_state = iqspm_pkg::FS_WGT1;
            iqspm_pkg::FS_WGT1:    n_state = iqspm_pkg::FS_WGT2;
            iqspm_pkg::FS_WGT2:    n_state = iqspm_pkg::FS_INNER_C;
            iqspm_pkg::FS_INNER_C: n_state = iqspm_pkg::FS_INNER_D;
            iqspm_pkg::FS_INNER_D: begin
                // hold here while the queue is full
                if (!i_q_full) begin
                    o_q_push = 1'b1;
                    o_ready  = 1'b1;
                    n_state  = i_valid ? iqspm_pkg::FS_AB : iqspm_pkg::FS_IDLE;
                end
            end
            default: n_state = iqspm_pkg::FS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iqspm_pkg::FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a <= (i_coord_a > CONE) ? CONE : i_coord_a;
            r_b <= (i_coord_b > CONE) ? CONE : i_coord_b;
            r_c <= (i_coord_c > CONE) ? CONE : i_coord_c;
            r_d <= (i_coord_d > CONE) ? CONE : i_coord_d;
            r_w <= (i_weight_in > WONE) ? WONE : i_weight_in;
        end
        unique case (r_state)
            iqspm_pkg::FS_AB: begin
                r_ab <= prod_a[CW-1:0];
                r_aw <= prod_b;
            end
            iqspm_pkg::FS_WGT1: begin
                r_t0 <= prod_a;
                r_t1 <= prod_b;
            end
            iqspm_pkg::FS_WGT2: begin
                r_wt0 <= prod_a[WW-1:0];
                r_wt1 <= prod_b[WW-1:0];
            end
            iqspm_pkg::FS_INNER_C: begin
                r_cu0 <= prod_a[CW-1:0];
                r_cu1 <= prod_b[CW-1:0];
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== hdl/iqspm_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqspm_fifo
// Short first-word-fall-through queue between the front and back ends.
// ----------------------------------------------------------------------------
module iqspm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [NW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + NW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - NW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== hdl/iqspm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqspm_back
// Takes one queued record and emits its eight reflected results, one a cycle
// while the output is not stalled, through an output register.
// ----------------------------------------------------------------------------
module iqspm_back #(
    parameter int COORD_FRAC_BITS  = 16,
    parameter int WEIGHT_FRAC_BITS = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_q_empty,
    input  logic [6*(COORD_FRAC_BITS+1)+2*(WEIGHT_FRAC_BITS+1)-1:0] i_q_data,
    output logic                                  o_q_pop,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [COORD_FRAC_BITS:0]              o_sum_x,
    output logic [COORD_FRAC_BITS:0]              o_sum_y,
    output logic [COORD_FRAC_BITS:0]              o_inner_u,
    output logic [COORD_FRAC_BITS:0]              o_inner_v,
    output logic signed [COORD_FRAC_BITS+1:0]     o_offset_x,
    output logic signed [COORD_FRAC_BITS+1:0]     o_offset_y,
    output logic [WEIGHT_FRAC_BITS:0]             o_weight_out,
    output logic                                  o_pyramid,
    output logic [1:0]                            o_reflection,
    output logic                                  o_last
);

    localparam int CW = COORD_FRAC_BITS + 1;
    localparam int SW = COORD_FRAC_BITS + 2;
    localparam int WW = WEIGHT_FRAC_BITS + 1;
    localparam int RW = $clog2(iqspm_pkg::RES_PER_ITEM);

    logic [$bits(i_q_data)-1:0] r_rec;
    logic                       r_have;
    logic [RW-1:0]              r_idx;
    logic                       r_valid;

    logic [CW-1:0] q_a, q_ab, q_cu0, q_cu1, q_dv0, q_dv1;
    logic [WW-1:0] q_wt0, q_wt1;
    logic          load, idx_last, pyr, neg_x, neg_y;
    logic [1:0]    refl;
    logic [CW-1:0] px, py, cu, dv;
    logic [SW-1:0] u_full, v_full, sx_full, sy_full, ox_full, oy_full;

    assign {q_a, q_ab, q_cu0, q_cu1, q_dv0, q_dv1, q_wt0, q_wt1} = r_rec;

    // result index: reflection outer, pyramid inner
    assign pyr      = r_idx[0];
    assign refl     = r_idx[RW-1:1];
    assign neg_x    = refl[iqspm_pkg::REFL_NEG_X_BIT];
    assign neg_y    = refl[iqspm_pkg::REFL_NEG_Y_BIT];
    assign idx_last = (r_idx == RW'(iqspm_pkg::RES_PER_ITEM - 1));

    assign px = pyr ? q_a  : q_ab;
    assign py = pyr ? q_ab : q_a;
    assign cu = pyr ? q_cu1 : q_cu0;
    assign dv = pyr ? q_dv1 : q_dv0;

    assign u_full  = (neg_x ? SW'(px) : '0) + SW'(cu);
    assign v_full  = (neg_y ? SW'(py) : '0) + SW'(dv);
    assign sx_full = neg_x ? u_full - SW'(px) : u_full + SW'(px);
    assign sy_full = neg_y ? v_full - SW'(py) : v_full + SW'(py);
    assign ox_full = neg_x ? SW'(0) - SW'(px) : SW'(px);
    assign oy_full = neg_y ? SW'(0) - SW'(py) : SW'(py);

    assign load    = r_have && (!r_valid || i_ready);
    assign o_q_pop = !i_q_empty && (!r_have || (load && idx_last));
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have  <= 1'b0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_have <= 1'b1;
                r_idx  <= '0;
            end else if (load) begin
                // drop the record after its final result
                r_have <= !idx_last;
                r_idx  <= r_idx + RW'(1);
            end
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_rec <= i_q_data;
        end
        if (load) begin
            o_sum_x      <= sx_full[CW-1:0];
            o_sum_y      <= sy_full[CW-1:0];
            o_inner_u    <= u_full[CW-1:0];
            o_inner_v    <= v_full[CW-1:0];
            o_offset_x   <= ox_full;
            o_offset_y   <= oy_full;
            o_weight_out <= pyr ? q_wt1 : q_wt0;
            o_pyramid    <= pyr;
            o_reflection <= refl;
            o_last       <= idx_last;
        end
    end

endmodule

// ===== hdl/iqspm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqspm_checker
// Port-level checks on the result channel of the singular point map.
// ----------------------------------------------------------------------------
module iqspm_checker #(
    parameter int COORD_FRAC_BITS  = 16,
    parameter int WEIGHT_FRAC_BITS = 24
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_valid,
    input logic                              i_ready,
    input logic signed [COORD_FRAC_BITS+1:0] o_offset_x,
    input logic signed [COORD_FRAC_BITS+1:0] o_offset_y,
    input logic [WEIGHT_FRAC_BITS:0]         o_weight_out,
    input logic                              o_pyramid,
    input logic [1:0]                        o_reflection,
    input logic                              o_last
);

    localparam logic [WEIGHT_FRAC_BITS:0] WONE = (WEIGHT_FRAC_BITS + 1)'(1) << WEIGHT_FRAC_BITS;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_weight_out) && $stable(o_reflection)
                                && $stable(o_pyramid))
        else $error("stalled result changed");

    // last marks exactly the final pyramid of the final reflection
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == (o_pyramid && (o_reflection == iqspm_pkg::REFL_BOTH))))
        else $error("last flag out of step with result index");

    // results of one item follow without gaps, in index order
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last |=> o_valid
            && ({o_reflection, o_pyramid} == $past({o_reflection, o_pyramid}) + 3'd1))
        else $error("results of an item out of order or broken up");

    // offsets are non-negative unless their reflection negates them
    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_reflection[iqspm_pkg::REFL_NEG_X_BIT] || !o_offset_x[COORD_FRAC_BITS+1])
                 && (o_reflection[iqspm_pkg::REFL_NEG_Y_BIT] || !o_offset_y[COORD_FRAC_BITS+1]))
        else $error("offset sign disagrees with reflection");

    a_wbound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_weight_out <= WONE)
        else $error("weight above one");

endmodule

bind identical_quad_singular_point_map_core iqspm_checker #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
) u_iqspm_checker (.*);
